[sv/pot_pkg.sv]
`timescale 1ns / 1ps

package pot_pkg;

  // image centre, focal scale and output limit
  localparam int CenterX    = 320;
  localparam int CenterY    = 240;
  localparam int FocalDiv   = 100;
  localparam int OutLimit   = 45;
  localparam int FieldLimit = 63;
  localparam int ClampLim   = (OutLimit > FieldLimit) ? FieldLimit : OutLimit;

  // drive = num / 2560, 2560 = 512 * 5
  localparam int DriveDiv    = 2560;
  localparam int ClampScaled = ClampLim * DriveDiv;

  // |height * offset| < 2^26, so a 26-bit reciprocal shift leaves at most one off
  localparam int MagW       = 26;
  localparam int RecipShift = 26;
  localparam int RecipW     = 27;
  localparam logic [RecipW-1:0] RecipMul = RecipW'((64'd1 << RecipShift) / FocalDiv);

  localparam int ErrW = 24;
  localparam logic signed [ErrW-1:0] ErrMax = 24'sh7fffff;
  localparam logic signed [ErrW-1:0] ErrMin = 24'sh800000;

  localparam logic OpHeight = 1'b0;
  localparam logic OpTarget = 1'b1;

  typedef struct packed {
    logic load_height;
    logic load_item;
    logic en_prod;
    logic en_recip;
    logic en_qmul;
    logic en_corr;
    logic en_drive;
    logic en_sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[sv/pixel_offset_pd_tracker.sv]
`timescale 1ns / 1ps
// channel  handshake                  beat
// in       in_valid_i / in_stall_o    op, height_q8, pixel_x, pixel_y, target_seen
// out      out_valid_o / out_stall_i  speed_x, speed_y, tracking
// cfg      psel/penable/pwrite/pready prop_gain at 0x0, deriv_gain at 0x4
//
// height beat: taken in the accept cycle, no result; the next beat can follow at once.
// seen target: the result register is loaded by the six-step scale, reciprocal divide
// and drive sequence (prod, recip, qmul, corr, drive, sum) plus the emit step.
// unseen target: straight to the emit step, which loads the result register once the output is free.
// a stalled result holds the sequencer in its last step, and a new beat is taken
// at the edge after the result register is loaded.
// reset clears gains to 150 / 30, height and stored errors to zero.

module pixel_offset_pd_tracker import pot_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [15:0]       height_q8_i,
  input  logic [9:0]        pixel_x_i,
  input  logic [9:0]        pixel_y_i,
  input  logic              target_seen_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [6:0] speed_x_o,
  output logic signed [6:0] speed_y_o,
  output logic              tracking_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic RegPropGain  = 1'b0;
  localparam logic RegDerivGain = 1'b1;

  logic [7:0] prop_gain_q;
  logic [6:0] deriv_gain_q;
  logic       cfg_wr;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= 8'd150;
      deriv_gain_q <= 7'd30;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegPropGain:  prop_gain_q  <= pwdata[7:0];
        RegDerivGain: deriv_gain_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegPropGain:  prdata = {24'b0, prop_gain_q};
      RegDerivGain: prdata = {25'b0, deriv_gain_q};
      default:      prdata = '0;
    endcase
  end

  pot_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .op_i          (op_i),
    .target_seen_i (target_seen_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .in_stall_o    (in_stall_o)
  );

  pot_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .height_q8_i   (height_q8_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .target_seen_i (target_seen_i),
    .prop_gain_i   (prop_gain_q),
    .deriv_gain_i  (deriv_gain_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .speed_x_o     (speed_x_o),
    .speed_y_o     (speed_y_o),
    .tracking_o    (tracking_o)
  );

  // unseen target reports zero drives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tracking_o) |-> (speed_x_o == 7'sd0 && speed_y_o == 7'sd0))
    else $error("untracked result with nonzero drive");

  // drives never leave the clamp window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(speed_x_o) <= $signed(7'(ClampLim)) &&
                     $signed(speed_x_o) >= -$signed(7'(ClampLim)) &&
                     $signed(speed_y_o) <= $signed(7'(ClampLim)) &&
                     $signed(speed_y_o) >= -$signed(7'(ClampLim))))
    else $error("drive outside clamp limit");

  // the sequencer only goes busy after taking a target beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && (op_i == OpTarget)))
    else $error("busy without a target beat");

  // a new result is loaded only when the previous one is gone or taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(speed_x_o) &&
                                      $stable(speed_y_o) && $stable(tracking_o)))
    else $error("stalled result overwritten");

endmodule

[sv/pot_lane.sv]
`timescale 1ns / 1ps

module pot_lane import pot_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [15:0]              height_i,
  input  logic signed [10:0]       offset_i,
  input  logic [7:0]               prop_gain_i,
  input  logic [6:0]               deriv_gain_i,
  output logic signed [6:0]        speed_o
);

  logic                   sign_q, sign_d;
  logic [MagW-1:0]        mag_q, mag_d;
  logic [MagW-1:0]        q0_q, q0_d;
  logic [MagW-1:0]        qd_q, qd_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic signed [ErrW-1:0] prev_q;
  logic signed [32:0]     pterm_q, pterm_d;
  logic signed [36:0]     dterm_q, dterm_d;
  logic                   big_q, big_d;
  logic                   nsign_q, nsign_d;
  logic [8:0]             low_q, low_d;

  logic signed [27:0] prod;
  logic [27:0]        prod_abs;
  logic [52:0]        recip_full;
  logic [35:0]        qd_full;
  logic [MagW-1:0]    rem;
  logic [MagW:0]      quo;
  logic signed [24:0] diff;
  logic [10:0]        dg10;
  logic signed [37:0] num;
  logic [37:0]        num_abs;
  logic [16:0]        div5;
  logic [6:0]         vmag;

  // height times pixel offset, kept as sign and magnitude
  assign prod     = $signed({1'b0, height_i}) * offset_i;
  assign sign_d   = prod[27];
  assign prod_abs = sign_d ? 28'(-prod) : 28'(prod);
  assign mag_d    = prod_abs[MagW-1:0];

  // reciprocal estimate, low by at most one
  assign recip_full = {27'b0, mag_q} * {26'b0, RecipMul};
  assign q0_d       = recip_full[RecipShift +: MagW];

  assign qd_full = {10'b0, q0_q} * 36'(FocalDiv);
  assign qd_d    = qd_full[MagW-1:0];

  assign rem = mag_q - qd_q;
  assign quo = {1'b0, q0_q} + (MagW+1)'(rem >= MagW'(FocalDiv));

  always_comb begin
    if (sign_q) begin
      if (quo > (MagW+1)'(27'd8388608)) err_d = ErrMin;
      else err_d = -$signed(quo[ErrW-1:0]);
    end else begin
      if (quo > (MagW+1)'(27'd8388607)) err_d = ErrMax;
      else err_d = $signed(quo[ErrW-1:0]);
    end
  end

  assign diff    = {err_q[ErrW-1], err_q} - {prev_q[ErrW-1], prev_q};
  assign dg10    = 11'({deriv_gain_i, 3'b0}) + 11'({deriv_gain_i, 1'b0});
  assign pterm_d = $signed({1'b0, prop_gain_i}) * err_q;
  assign dterm_d = $signed({1'b0, dg10}) * diff;

  assign num     = {{5{pterm_q[32]}}, pterm_q} + {dterm_q[36], dterm_q};
  assign nsign_d = num[37];
  assign num_abs = nsign_d ? 38'(-num) : 38'(num);
  assign big_d   = num_abs >= 38'(ClampScaled);
  // below the clamp the magnitude fits 18 bits: take /512 here, /5 at the end
  assign low_d   = num_abs[17:9];

  assign div5    = {8'b0, low_q} * 17'd205;
  assign vmag    = big_q ? 7'(ClampLim) : div5[16:10];
  assign speed_o = nsign_q ? -$signed(vmag) : $signed(vmag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.en_sum) begin
      prev_q <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en_prod) begin
      sign_q <= sign_d;
      mag_q  <= mag_d;
    end
    if (cmd_i.en_recip) q0_q <= q0_d;
    if (cmd_i.en_qmul) qd_q <= qd_d;
    if (cmd_i.en_corr) err_q <= err_d;
    if (cmd_i.en_drive) begin
      pterm_q <= pterm_d;
      dterm_q <= dterm_d;
    end
    if (cmd_i.en_sum) begin
      big_q   <= big_d;
      nsign_q <= nsign_d;
      low_q   <= low_d;
    end
  end

endmodule

[sv/pot_datapath.sv]
`timescale 1ns / 1ps

module pot_datapath import pot_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [15:0]        height_q8_i,
  input  logic [9:0]         pixel_x_i,
  input  logic [9:0]         pixel_y_i,
  input  logic               target_seen_i,
  input  logic [7:0]         prop_gain_i,
  input  logic [6:0]         deriv_gain_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [6:0]  speed_x_o,
  output logic signed [6:0]  speed_y_o,
  output logic               tracking_o
);

  logic [15:0]        height_q;
  logic signed [10:0] dx_q, dx_d;
  logic signed [10:0] dy_q, dy_d;
  logic               seen_q;
  logic               out_valid_q, out_valid_d;
  logic signed [6:0]  speed_x_q, speed_y_q;
  logic               tracking_q;
  logic signed [6:0]  lane_x, lane_y;

  assign dx_d = $signed({1'b0, pixel_x_i}) - $signed(11'(CenterX));
  assign dy_d = $signed(11'(CenterY)) - $signed({1'b0, pixel_y_i});

  pot_lane u_lane_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .height_i     (height_q),
    .offset_i     (dx_q),
    .prop_gain_i  (prop_gain_i),
    .deriv_gain_i (deriv_gain_i),
    .speed_o      (lane_x)
  );

  pot_lane u_lane_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .height_i     (height_q),
    .offset_i     (dy_q),
    .prop_gain_i  (prop_gain_i),
    .deriv_gain_i (deriv_gain_i),
    .speed_o      (lane_y)
  );

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cmd_i.emit) out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_height) height_q <= height_q8_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      seen_q <= target_seen_i;
    end
    // an unseen target reports zero drives
    if (cmd_i.emit) begin
      speed_x_q  <= seen_q ? lane_x : '0;
      speed_y_q  <= seen_q ? lane_y : '0;
      tracking_q <= seen_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign speed_x_o   = speed_x_q;
  assign speed_y_o   = speed_y_q;
  assign tracking_o  = tracking_q;

endmodule

[sv/pot_ctrl.sv]
`timescale 1ns / 1ps

module pot_ctrl import pot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic op_i,
  input  logic target_seen_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  typedef enum logic [2:0] {
    StIdle,
    StProd,
    StRecip,
    StQmul,
    StCorr,
    StDrive,
    StSum,
    StEmit
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   accept;

  assign accept     = in_valid_i && !stall_q;
  assign in_stall_o = stall_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.load_height = accept && (op_i == OpHeight);
    cmd_o.load_item   = accept && (op_i == OpTarget);
    cmd_o.en_prod     = (state_q == StProd);
    cmd_o.en_recip    = (state_q == StRecip);
    cmd_o.en_qmul     = (state_q == StQmul);
    cmd_o.en_corr     = (state_q == StCorr);
    cmd_o.en_drive    = (state_q == StDrive);
    cmd_o.en_sum      = (state_q == StSum);
    cmd_o.emit        = (state_q == StEmit) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          // height beats finish in the accept cycle
          if (accept && (op_i == OpTarget)) begin
            stall_q <= 1'b1;
            state_q <= target_seen_i ? StProd : StEmit;
          end
        end
        StProd:  state_q <= StRecip;
        StRecip: state_q <= StQmul;
        StQmul:  state_q <= StCorr;
        StCorr:  state_q <= StDrive;
        StDrive: state_q <= StSum;
        StSum:   state_q <= StEmit;
        StEmit: begin
          if (sts_i.out_free) begin
            stall_q <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
